### rtl/cartridge_rom_bank_mapper_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef CARTRIDGE_ROM_BANK_MAPPER_UNIT_MACROS_SVH
`define CARTRIDGE_ROM_BANK_MAPPER_UNIT_MACROS_SVH

// Check a property on clk_i, ignored while reset is asserted.
`define CRBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on clk_i at every edge, reset included.
`define CRBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/crbm_pkg.sv
package crbm_pkg;

  localparam int unsigned ROM_BYTES_W = 23;
  localparam int unsigned ROM_ADDR_W  = 22;
  localparam int unsigned OFFSET_W    = 14;
  localparam int unsigned PAGE_W      = 8;
  localparam int unsigned PAGES_W     = 10;
  localparam int unsigned RAM_AW      = 13;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned REM_W       = ROM_BYTES_W;

  localparam int unsigned PAGE_BYTES     = 16384;
  localparam int unsigned CART_RAM_BYTES = 8192;

  // Cart RAM window 0xA000-0xBFFF: top three address bits
  localparam logic [2:0] RAM_WINDOW = 3'b101;

  localparam logic [DATA_W-1:0] NO_ROM_BYTE = 8'hFF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    SRC_WRITE = 2'd0,
    SRC_ROM   = 2'd1,
    SRC_RAM   = 2'd2,
    SRC_NOROM = 2'd3
  } src_e;

endpackage

### rtl/crbm_rem_step.sv
// One restoring remainder step: shift in a bit, subtract the divisor if it fits.
module crbm_rem_step import crbm_pkg::*; (
  input  logic [REM_W-1:0] rem_i,
  input  logic             bit_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic [REM_W-1:0] rem_o
);

  logic [REM_W:0] cand;
  logic [REM_W:0] diff;

  assign cand  = {rem_i, bit_i};
  assign diff  = cand - {1'b0, divisor_i};
  assign rem_o = (cand >= {1'b0, divisor_i}) ? diff[REM_W-1:0] : cand[REM_W-1:0];

endmodule

### rtl/cartridge_rom_bank_mapper_unit.sv
// Channel | Direction | Handshake               | Beat payload
// --------+-----------+-------------------------+--------------------------------------
// in      | in        | in_valid_i / in_stall_o | in_op_i, in_address_i, in_write_data_i
// out     | out       | out_valid_o/out_stall_i | out_source_o, out_rom_address_o,
//         |           |                         | out_read_data_o
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_rom_bytes_i
//
// One access at a time. A write, a cart RAM read or a read with no ROM loaded
// goes straight to the result; a ROM read runs through the shared
// one-bit-per-cycle remainder unit: 8 steps for page mod pages, then 1 fold
// step for a ROM of 16 KiB or more or 14 offset steps for a smaller ROM.
// An output stall lengthens an access. After reset the cart RAM is swept to
// zero, one byte a cycle, with in_stall_o high; cfg writes are taken at any time.
module cartridge_rom_bank_mapper_unit import crbm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // access input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_op_i,
  input  logic [ADDR_W-1:0]      in_address_i,
  input  logic [DATA_W-1:0]      in_write_data_i,
  // result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             out_source_o,
  output logic [ROM_ADDR_W-1:0]  out_rom_address_o,
  output logic [DATA_W-1:0]      out_read_data_o,
  // ROM size register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ROM_BYTES_W-1:0] cfg_rom_bytes_i
);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PMOD  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OMOD  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [3:0] PmodLast = 4'(PAGE_W - 1);
  localparam logic [3:0] OmodLast = 4'(OFFSET_W - 1);

  logic [2:0]             state_q, state_d;
  logic [3:0]             cnt_q;
  logic [RAM_AW-1:0]      clr_addr_q;

  logic [PAGE_W-1:0]      page0_q, page1_q, page2_q;
  logic                   ram_enable_q;
  logic [ROM_BYTES_W-1:0] rom_bytes_q;
  logic [PAGES_W-1:0]     pages_q;

  logic [REM_W-1:0]       rem_q;
  logic [OFFSET_W-1:0]    sh_q;
  logic [OFFSET_W-1:0]    off_q;
  src_e                   res_src_q;
  logic [DATA_W-1:0]      ram_rd_q;

  logic                   out_valid_q;
  logic [1:0]             out_source_q;
  logic [ROM_ADDR_W-1:0]  out_rom_address_q;
  logic [DATA_W-1:0]      out_read_data_q;

  logic [DATA_W-1:0]      cart_ram [CART_RAM_BYTES];

  logic                   in_accept;
  logic                   cfg_accept;
  logic                   ram_win_hit;
  logic                   ram_we;
  logic [RAM_AW-1:0]      ram_wa;
  logic [DATA_W-1:0]      ram_wd;
  logic [PAGE_W-1:0]      sel_page;
  logic                   big_rom;
  logic                   out_free;
  logic [ROM_BYTES_W:0]   pages_sum;

  logic [REM_W-1:0]       step_rem;
  logic                   step_bit;
  logic [REM_W-1:0]       step_div;
  logic [REM_W-1:0]       step_out;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_accept = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // 0xA000-0xBFFF with the RAM switched on
  assign ram_win_hit = ram_enable_q && (in_address_i[ADDR_W-1:RAM_AW] == RAM_WINDOW);
  assign big_rom       = (rom_bytes_q[ROM_BYTES_W-1:OFFSET_W] != '0);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign pages_sum     = {1'b0, cfg_rom_bytes_i} + (ROM_BYTES_W+1)'(PAGE_BYTES - 1);

  always_comb begin
    case (in_address_i[ADDR_W-1:OFFSET_W])
      2'b00:   sel_page = page0_q;
      2'b01:   sel_page = page1_q;
      default: sel_page = page2_q;
    endcase
  end

  // Cart RAM port: the clearing sweep owns it until the block first goes idle
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_addr_q;
      ram_wd = '0;
    end else begin
      ram_we = in_accept && (in_op_i == OP_WRITE) && ram_win_hit;
      ram_wa = in_address_i[RAM_AW-1:0];
      ram_wd = in_write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      cart_ram[ram_wa] <= ram_wd;
    end
    if (in_accept) begin
      ram_rd_q <= cart_ram[in_address_i[RAM_AW-1:0]];
    end
  end

  // Feed the shared remainder unit.
  // Fold: the fetch address is below twice the ROM size, so one step reduces it.
  always_comb begin
    case (state_q)
      S_PMOD: begin
        step_rem = rem_q;
        step_bit = sh_q[OFFSET_W-1];
        step_div = REM_W'(pages_q);
      end
      S_FOLD: begin
        step_rem = REM_W'({rem_q[PAGE_W-1:0], off_q[OFFSET_W-1:1]});
        step_bit = off_q[0];
        step_div = rom_bytes_q;
      end
      default: begin
        step_rem = rem_q;
        step_bit = sh_q[OFFSET_W-1];
        step_div = rom_bytes_q;
      end
    endcase
  end

  crbm_rem_step u_rem_step (
    .rem_i     (step_rem),
    .bit_i     (step_bit),
    .divisor_i (step_div),
    .rem_o     (step_out)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if ((in_op_i == OP_WRITE) || ram_win_hit || (rom_bytes_q == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PMOD;
          end
        end
      end
      S_PMOD: begin
        if (cnt_q == PmodLast) begin
          state_d = big_rom ? S_FOLD : S_OMOD;
        end
      end
      S_FOLD: state_d = S_DONE;
      S_OMOD: begin
        if (cnt_q == OmodLast) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      clr_addr_q   <= '0;
      page0_q      <= 8'd0;
      page1_q      <= 8'd1;
      page2_q      <= 8'd0;
      ram_enable_q <= 1'b0;
      rom_bytes_q  <= '0;
      pages_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + RAM_AW'(1);
      end
      // Count remainder steps; restart at every phase boundary
      if ((state_q == S_PMOD) && (cnt_q != PmodLast)) begin
        cnt_q <= cnt_q + 4'd1;
      end else if ((state_q == S_OMOD) && (cnt_q != OmodLast)) begin
        cnt_q <= cnt_q + 4'd1;
      end else begin
        cnt_q <= '0;
      end
      if (cfg_accept) begin
        rom_bytes_q <= cfg_rom_bytes_i;
        pages_q     <= pages_sum[ROM_BYTES_W:OFFSET_W];
      end
      // Bank writes land at the accept edge
      if (in_accept && (in_op_i == OP_WRITE)) begin
        case (in_address_i[ADDR_W-1:OFFSET_W])
          2'b00: page0_q <= in_write_data_i;
          2'b01: begin
            page1_q      <= in_write_data_i;
            ram_enable_q <= in_write_data_i[DATA_W-1];
          end
          default: begin
            if (!ram_win_hit) begin
              page2_q <= in_write_data_i;
            end
          end
        endcase
      end
      // Load a new beat, or drop the one the receiver took
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          rem_q <= '0;
          sh_q  <= {sel_page, {(OFFSET_W-PAGE_W){1'b0}}};
          off_q <= in_address_i[OFFSET_W-1:0];
          if (in_op_i == OP_WRITE) begin
            res_src_q <= SRC_WRITE;
          end else if (ram_win_hit) begin
            res_src_q <= SRC_RAM;
          end else if (rom_bytes_q == '0) begin
            res_src_q <= SRC_NOROM;
          end else begin
            res_src_q <= SRC_ROM;
          end
        end
      end
      S_PMOD: begin
        if (cnt_q == PmodLast) begin
          // Small ROM: page mod one page is zero, so reduce the offset alone
          sh_q  <= off_q;
          rem_q <= big_rom ? step_out : '0;
        end else begin
          rem_q <= step_out;
          sh_q  <= {sh_q[OFFSET_W-2:0], 1'b0};
        end
      end
      S_FOLD: rem_q <= step_out;
      S_OMOD: begin
        rem_q <= step_out;
        sh_q  <= {sh_q[OFFSET_W-2:0], 1'b0};
      end
      default: ;
    endcase
    if ((state_q == S_DONE) && out_free) begin
      out_source_q      <= res_src_q;
      out_rom_address_q <= (res_src_q == SRC_ROM) ? rem_q[ROM_ADDR_W-1:0] : '0;
      case (res_src_q)
        SRC_RAM:   out_read_data_q <= ram_rd_q;
        SRC_NOROM: out_read_data_q <= NO_ROM_BYTE;
        default:   out_read_data_q <= '0;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_source_o      = out_source_q;
  assign out_rom_address_o = out_rom_address_q;
  assign out_read_data_o   = out_read_data_q;

endmodule

### rtl/crbm_checker.sv
`include "cartridge_rom_bank_mapper_unit_macros.svh"

module crbm_checker import crbm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            out_source_o,
  input logic [ROM_ADDR_W-1:0] out_rom_address_o,
  input logic [DATA_W-1:0]     out_read_data_o
);

  `CRBM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled beat dropped")
  `CRBM_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "second beat taken while busy")
  `CRBM_ASSERT(a_addr_only_rom, out_valid_o && (out_source_o != SRC_ROM) |-> out_rom_address_o == '0, "rom address on non-ROM beat")
  `CRBM_ASSERT(a_norom_byte, out_valid_o && (out_source_o == SRC_NOROM) |-> out_read_data_o == NO_ROM_BYTE, "no-ROM beat without 0xFF")
  `CRBM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o && in_stall_o, "activity right after reset")

endmodule

bind cartridge_rom_bank_mapper_unit crbm_checker u_crbm_checker (.*);

### tb/tb_cartridge_rom_bank_mapper_unit.sv
module tb_cartridge_rom_bank_mapper_unit;
  import crbm_pkg::*;

  // Clock period is 8; the access loop runs on the same clock.
  localparam int unsigned RESET_CYCLES  = 9;
  // Slowest access is a small-ROM read; give margin before a size change.
  localparam int unsigned DRAIN_CYCLES  = 32;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_BEATS   = 175;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam int unsigned DIR_ROWS      = 31;

  // Address map of the CPU bus.
  localparam logic [ADDR_W-1:0] SLOT1_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] SLOT2_BASE = 16'h8000;
  localparam logic [ADDR_W-1:0] RAM_BASE   = 16'hA000;
  localparam logic [ADDR_W-1:0] RAM_TOP    = 16'hBFFF;
  localparam logic [ADDR_W-1:0] UPPER_BASE = 16'hC000;

  // Row kinds and checking modes of the directed plan.
  localparam logic ROW_ACC   = 1'b0;
  localparam logic ROW_CFG   = 1'b1;
  localparam logic CHK_PRED  = 1'b0;
  localparam logic CHK_TYPED = 1'b1;

  typedef struct packed {
    src_e                  source;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_data;
  } bus_result_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [ROM_BYTES_W-1:0] rom_size;
    logic                   op;
    logic [ADDR_W-1:0]      address;
    logic [DATA_W-1:0]      write_data;
    logic                   typed;
    bus_result_t            result;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   in_op_i = OP_READ;
  logic [ADDR_W-1:0]      in_address_i = '0;
  logic [DATA_W-1:0]      in_write_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             out_source_o;
  logic [ROM_ADDR_W-1:0]  out_rom_address_o;
  logic [DATA_W-1:0]      out_read_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [ROM_BYTES_W-1:0] cfg_rom_bytes_i = '0;

  cartridge_rom_bank_mapper_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_op_i           (in_op_i),
    .in_address_i      (in_address_i),
    .in_write_data_i   (in_write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_source_o      (out_source_o),
    .out_rom_address_o (out_rom_address_o),
    .out_read_data_o   (out_read_data_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_rom_bytes_i   (cfg_rom_bytes_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the mapper state, advanced on every accepted beat.
  logic [PAGE_W-1:0]      bank_page [3];
  logic                   ram_on;
  logic [DATA_W-1:0]      cart_mem [CART_RAM_BYTES];
  logic [ROM_BYTES_W-1:0] rom_size;

  bus_result_t pending_results [$];

  // Typed expectation of the beat currently on the access port, if any.
  logic        beat_typed = CHK_PRED;
  bus_result_t beat_result;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned accesses = 0;
  int unsigned writes_taken = 0;
  int unsigned size_writes = 0;
  int unsigned seen_by_source [4];

  plan_row_t access_plan [DIR_ROWS];

  // Compute the result of one access and update the shadow state as the
  // mapper would.
  function automatic bus_result_t predict_access(logic op, logic [ADDR_W-1:0] addr,
                                                 logic [DATA_W-1:0] wdata);
    bus_result_t res;
    logic        ram_hit;
    logic [PAGE_W-1:0] page;
    int unsigned size;
    int unsigned pages;
    int unsigned phys;
    res = '{SRC_WRITE, '0, '0};
    ram_hit = ram_on && (addr[15:13] == RAM_WINDOW);
    if (op == OP_WRITE) begin
      if (addr < SLOT1_BASE) begin
        bank_page[0] = wdata;
      end else if (addr < SLOT2_BASE) begin
        bank_page[1] = wdata;
        ram_on = wdata[7];
      end else if (ram_hit) begin
        cart_mem[addr[RAM_AW-1:0]] = wdata;
      end else begin
        bank_page[2] = wdata;
      end
      return res;
    end
    if (ram_hit) begin
      res.source = SRC_RAM;
      res.read_data = cart_mem[addr[RAM_AW-1:0]];
      return res;
    end
    // Slots 0 and 1 use their own page; everything from 0x8000 up uses page 2.
    page = addr[15] ? bank_page[2] : bank_page[addr[14]];
    size = 32'(rom_size);
    if (size == 0) begin
      res.source = SRC_NOROM;
      res.read_data = NO_ROM_BYTE;
      return res;
    end
    pages = (size + PAGE_BYTES - 1) >> OFFSET_W;
    phys = ((32'(page) % pages) << OFFSET_W) | 32'(addr[OFFSET_W-1:0]);
    // A short last page wraps back into the ROM.
    if (phys >= size) begin
      phys = phys % size;
    end
    res.source = SRC_ROM;
    res.rom_address = phys[ROM_ADDR_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Receiver side: stall the result port at random, per the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Scoreboard: sample all three channels at the rising edge.
  always @(posedge clk_i) begin : scoreboard
    bus_result_t want;
    bus_result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        rom_size = cfg_rom_bytes_i;
        size_writes++;
      end
      // Predict first, so the queue is current before any result is popped.
      if (in_valid_i && !in_stall_o) begin
        want = predict_access(in_op_i, in_address_i, in_write_data_i);
        pending_results.push_back(beat_typed ? beat_result : want);
        accesses++;
        if (in_op_i == OP_WRITE) begin
          writes_taken++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{src_e'(out_source_o), out_rom_address_o, out_read_data_o};
        seen_by_source[out_source_o]++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat, source", out_source_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.source != want.source) begin
            report_mismatch("source", got.source, want.source);
          end
          if (got.rom_address != want.rom_address) begin
            report_mismatch("rom_address", got.rom_address, want.rom_address);
          end
          if (got.read_data != want.read_data) begin
            report_mismatch("read_data", got.read_data, want.read_data);
          end
        end
      end
    end
  end

  // Present one access beat and hold it until the mapper takes it.
  task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                             logic typed, bus_result_t result);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    in_op_i         <= op;
    in_address_i    <= addr;
    in_write_data_i <= wdata;
    beat_typed  = typed;
    beat_result = result;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain the mapper, then write a new ROM size.
  task automatic write_rom_size(logic [ROM_BYTES_W-1:0] size);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_rom_bytes_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    plan_row_t              row;
    logic                   op;
    logic [ADDR_W-1:0]      addr;
    logic [DATA_W-1:0]      wdata;
    logic [ROM_BYTES_W-1:0] size;
    bus_result_t            no_typed;

    no_typed = '{SRC_WRITE, '0, '0};
    bank_page[0] = 8'd0;
    bank_page[1] = 8'd1;
    bank_page[2] = 8'd0;
    ram_on = 1'b0;
    rom_size = '0;
    foreach (cart_mem[i]) cart_mem[i] = '0;
    foreach (seen_by_source[i]) seen_by_source[i] = 0;

    // Directed plan: ROM size changes interleaved with accesses. Typed rows
    // carry the obvious answer; the rest go through the predictor.
    access_plan = '{
      // no ROM loaded: any ROM read answers 0xFF
      '{ROW_CFG, 23'd0,       OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h0000, 8'h00, CHK_TYPED,
        '{SRC_NOROM, 22'd0, NO_ROM_BYTE}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hFFFF, 8'h00, CHK_TYPED,
        '{SRC_NOROM, 22'd0, NO_ROM_BYTE}},
      // enable cart RAM, store and read back at both window ends
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'h4000, 8'h80, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'hA000, 8'h5A, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hA000, 8'h00, CHK_TYPED, '{SRC_RAM, 22'd0, 8'h5A}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hBFFF, 8'h00, CHK_TYPED, '{SRC_RAM, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'hBFFF, 8'hFF, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hBFFF, 8'h00, CHK_TYPED, '{SRC_RAM, 22'd0, 8'hFF}},
      // full 4 MiB ROM: 256 pages, no wrap
      '{ROW_CFG, 23'd4194304, OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h0000, 8'h00, CHK_TYPED, '{SRC_ROM, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h7FFF, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'h0000, 8'hFF, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h3FFF, 8'h00, CHK_TYPED,
        '{SRC_ROM, 22'h3FFFFF, 8'h00}},
      // slot 1 write with bit 7 clear turns cart RAM off again
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'h7FFF, 8'h7F, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hA000, 8'h00, CHK_PRED,  no_typed},
      // upper quarter behaves as slot 2
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'hC000, 8'h03, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hFFFF, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'h9FFF, 8'hAA, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      // one byte past a page: partial last page wraps
      '{ROW_CFG, 23'd16385,   OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h8000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h4001, 8'h00, CHK_PRED,  no_typed},
      // single-byte ROM; write data on a read is ignored
      '{ROW_CFG, 23'd1,       OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h1234, 8'hFF, CHK_PRED,  no_typed},
      // oversized ROM, all size bits set
      '{ROW_CFG, 23'h7FFFFF,  OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h3FFF, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_WRITE, 16'h4000, 8'h80, CHK_TYPED, '{SRC_WRITE, 22'd0, 8'h00}},
      '{ROW_ACC, 23'd0,       OP_READ,  16'hB000, 8'h00, CHK_PRED,  no_typed},
      // one byte short of a page: a single page that wraps
      '{ROW_CFG, 23'd16383,   OP_READ,  16'h0000, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h3FFF, 8'h00, CHK_PRED,  no_typed},
      '{ROW_ACC, 23'd0,       OP_READ,  16'h5555, 8'h55, CHK_PRED,  no_typed}
    };

    // Hold reset, then release at a falling edge. The mapper sweeps its cart
    // RAM afterwards; in_stall_o covers that.
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (access_plan[i]) begin
      row = access_plan[i];
      if (row.is_cfg) begin
        write_rom_size(row.rom_size);
      end else begin
        send_access(row.op, row.address, row.write_data, row.typed, row.result);
      end
    end

    // Random phases: each one picks a ROM size and an idling mode.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: size = 23'd65536;
        1: size = 23'd0;
        2: size = 23'($urandom_range(1, PAGE_BYTES - 1));
        3: size = 23'd4194304;
        4: size = 23'h7FFFFF;
        5: size = 23'($urandom);
        6: size = 23'(PAGE_BYTES * $urandom_range(1, 255) + $urandom_range(0, PAGE_BYTES - 1));
        default: size = 23'(PAGE_BYTES);
      endcase
      // Change idling only while drained, so the new mode starts clean.
      gap_pct   = 0;
      stall_pct = 0;
      write_rom_size(size);
      case (p % 4)
        1: gap_pct = 46;
        2: stall_pct = 46;
        3: begin
          gap_pct   = 13;
          stall_pct = 13;
        end
        default: ;
      endcase

      for (int n = 0; n < PHASE_BEATS; n++) begin
        op = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_READ;
        wdata = 8'($urandom);
        case ($urandom_range(0, 5))
          0: addr = 16'($urandom_range(0, SLOT1_BASE - 1));
          1: addr = 16'($urandom_range(SLOT1_BASE, SLOT2_BASE - 1));
          // Keep half the window hits on a few bytes so reads find stored data.
          2, 3: addr = $urandom_range(0, 1) ? RAM_BASE + 16'($urandom_range(0, 31))
                                            : 16'($urandom_range(RAM_BASE, RAM_TOP));
          4: addr = 16'($urandom_range(SLOT2_BASE, RAM_BASE - 1));
          default: addr = 16'($urandom_range(UPPER_BASE, 16'hFFFF));
        endcase
        // Now and then land on a region boundary.
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 9))
            0: addr = 16'h0000;
            1: addr = 16'(SLOT1_BASE - 1);
            2: addr = SLOT1_BASE;
            3: addr = 16'(SLOT2_BASE - 1);
            4: addr = SLOT2_BASE;
            5: addr = 16'(RAM_BASE - 1);
            6: addr = RAM_BASE;
            7: addr = RAM_TOP;
            8: addr = UPPER_BASE;
            default: addr = 16'hFFFF;
          endcase
        end
        send_access(op, addr, wdata, CHK_PRED, no_typed);
      end
    end

    // Drop valid, wait for the last results, then let the mapper settle.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d accesses (%0d writes) over %0d ROM size settings and %0d phases.",
             accesses, writes_taken, size_writes, PHASES);
    $display("Results by source: write %0d, ROM %0d, cart RAM %0d, no ROM %0d; %0d mismatches.",
             seen_by_source[SRC_WRITE], seen_by_source[SRC_ROM], seen_by_source[SRC_RAM],
             seen_by_source[SRC_NOROM], mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
